>>> design/mog_pkg.sv
// ----------------------------------------------------------------------------
// mog_pkg
// Shared types and constants of the majority occupancy grid.
// ----------------------------------------------------------------------------
package mog_pkg;

   localparam int ROW_W      = 16;
   localparam int LANE_W     = 4;
   localparam int NUM_LANES  = ROW_W / LANE_W;
   localparam int LANE_CNT_W = $clog2(LANE_W + 1);
   localparam int ROW_CNT_W  = $clog2(ROW_W + 1);
   localparam int COUNT_W    = 9;
   localparam int CELL_W     = 5;
   localparam int SIDE_W     = 9;
   localparam int COORD_W    = 8;
   localparam int INDEX_W    = 16;
   localparam int IDX_W      = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [0:0] {
      CMD_SAMPLE = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_CELL_SIZE   = 2'd2
   } csr_index_type;

   typedef logic [NUM_LANES-1:0][LANE_CNT_W-1:0] lane_counts_type;

   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic               vote;
   } merge_result_type;

endpackage

>>> design/mog_ram.sv
// ----------------------------------------------------------------------------
// mog_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mog_ram #(
   parameter  int DATA_W = 1,
   parameter  int DEPTH  = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mog_lane.sv
// ----------------------------------------------------------------------------
// mog_lane
// Popcount of one slice of a sample row, masked to the effective cell size.
// ----------------------------------------------------------------------------
module mog_lane #(
   parameter int LANE_IDX = 0
) (
   input  logic [mog_pkg::LANE_W-1:0]     lane_bits,
   input  logic [mog_pkg::CELL_W-1:0]     cell_size,
   output logic [mog_pkg::LANE_CNT_W-1:0] lane_count
);
   import mog_pkg::*;

   always_comb begin
      lane_count = '0;
      for (int i = 0; i < LANE_W; i++) begin
         if (lane_bits[i] && (CELL_W'(LANE_IDX * LANE_W + i) < cell_size)) begin
            lane_count = lane_count + LANE_CNT_W'(1);
         end
      end
   end

endmodule

>>> design/mog_merge.sv
// ----------------------------------------------------------------------------
// mog_merge
// Combines lane counts, accumulates with saturation and takes the majority
// vote against half of the cell area.
// ----------------------------------------------------------------------------
module mog_merge (
   input  mog_pkg::lane_counts_type          lane_counts,
   input  logic [mog_pkg::COUNT_W-1:0]       count_prev,
   input  logic [mog_pkg::CELL_W-1:0]        cell_size,
   output mog_pkg::merge_result_type         result
);
   import mog_pkg::*;

   logic [ROW_CNT_W-1:0]  row_sum;
   logic [COUNT_W:0]      total_wide;
   logic [2*CELL_W-1:0]   area;
   logic [COUNT_W-1:0]    half_area;

   always_comb begin
      row_sum = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
         row_sum = row_sum + ROW_CNT_W'(lane_counts[l]);
      end
      total_wide = (COUNT_W + 1)'(count_prev) + (COUNT_W + 1)'(row_sum);
      area       = (2 * CELL_W)'(cell_size) * (2 * CELL_W)'(cell_size);
      half_area  = COUNT_W'(area >> 1);
      if (total_wide > (COUNT_W + 1)'(COUNT_MAX)) begin
         result.total = COUNT_MAX;
      end else begin
         result.total = COUNT_W'(total_wide);
      end
      result.vote = result.total > half_area;
   end

endmodule

>>> design/majority_occupancy_grid_unit.sv
// ----------------------------------------------------------------------------
// majority_occupancy_grid_unit
// Coarse solid-cell grid refreshed by majority vote over fine sample rows.
//
//   channel | dir | handshake            | payload
//   req_    | in  | req_valid/req_stall  | command, cell_x, cell_y, row_bits,
//           |     |                      | last_row, cell_index
//   rsp_    | out | rsp_valid/rsp_stall  | solid, in_range (queries only)
//   csr_    | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// One item per cycle while req_stall is low: a sample row is counted by
// parallel lanes and merged in the cycle after its transfer; a query passes
// stage 1, a map RAM read in stage 2 and the result register. Reset starts
// a pass that sets all MAX_GRID_SIDE * MAX_GRID_SIDE map entries solid, one
// per cycle, with req_stall high (65536 entries at the default). A stalled
// result keeps up to two more queries in flight behind it; sample rows keep
// flowing until a query waits in the first stage.
// ----------------------------------------------------------------------------
module majority_occupancy_grid_unit #(
   parameter int MAX_GRID_SIDE = 256,
   parameter int MAX_CELL_SIDE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [mog_pkg::COORD_W-1:0]       req_cell_x,
   input  logic [mog_pkg::COORD_W-1:0]       req_cell_y,
   input  logic [mog_pkg::ROW_W-1:0]         req_row_bits,
   input  logic                              req_last_row,
   input  logic [mog_pkg::INDEX_W-1:0]       req_cell_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_solid,
   output logic                              rsp_in_range,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mog_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mog_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mog_pkg::*;

   localparam int DEPTH    = MAX_GRID_SIDE * MAX_GRID_SIDE;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SIDE_CAP = (MAX_GRID_SIDE > 511) ? 511 : MAX_GRID_SIDE;
   localparam int CELL_CAP = (MAX_CELL_SIDE > 31) ? 31 : MAX_CELL_SIDE;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   // configuration
   logic [SIDE_W-1:0] grid_width_ff, grid_height_ff;
   logic [CELL_W-1:0] cell_size_ff;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: accepted item
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff;
   logic [COORD_W-1:0] s1_cell_x_ff, s1_cell_y_ff;
   logic [ROW_W-1:0]  s1_row_bits_ff;
   logic              s1_last_row_ff;
   logic [INDEX_W-1:0] s1_index_ff;

   // stage 2: map read in flight
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_in_range_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_solid_ff, rsp_in_range_ff;

   logic [COUNT_W-1:0] solid_count_ff, solid_count_in;

   logic              accept, s1_adv, s2_adv, s2_free;
   logic              s1_query, s1_sample;
   logic [SIDE_W-1:0] w_eff, h_eff;
   logic [CELL_W-1:0] cell_eff;
   logic [IDX_W-1:0]  cells, cell_idx;
   logic              query_in_range, write_in_range;

   lane_counts_type   lane_counts;
   merge_result_type  merge_out;

   logic              ram_we, ram_wdata, ram_re, ram_rdata;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;

   // --------------------------------------------------------------------------
   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIDE_W'(64);
         grid_height_ff <= SIDE_W'(64);
         cell_size_ff   <= CELL_W'(8);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data;
            CSR_CELL_SIZE:   cell_size_ff   <= csr_data[CELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // effective geometry
   always_comb begin
      w_eff = (grid_width_ff > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : grid_width_ff;
      h_eff = (grid_height_ff > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : grid_height_ff;
      if (cell_size_ff == '0) begin
         cell_eff = CELL_W'(1);
      end else if (cell_size_ff > CELL_W'(CELL_CAP)) begin
         cell_eff = CELL_W'(CELL_CAP);
      end else begin
         cell_eff = cell_size_ff;
      end
      cells          = IDX_W'(w_eff) * IDX_W'(h_eff);
      cell_idx       = IDX_W'(s1_cell_x_ff) + IDX_W'(s1_cell_y_ff) * IDX_W'(w_eff);
      query_in_range = IDX_W'(s1_index_ff) < cells;
      write_in_range = cell_idx < cells;
   end

   // --------------------------------------------------------------------------
   // handshake and pipeline advance
   assign s1_query  = s1_valid_ff && (s1_cmd_ff == CMD_QUERY);
   assign s1_sample = s1_valid_ff && (s1_cmd_ff == CMD_SAMPLE);
   assign s2_adv    = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s2_free   = !s2_valid_ff || s2_adv;
   assign s1_adv    = s1_sample || (s1_query && s2_free);
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s1_query && s2_free) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      solid_count_in = solid_count_ff;
      if (s1_sample) begin
         solid_count_in = s1_last_row_ff ? '0 : merge_out.total;
      end

      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clr_addr_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         solid_count_ff <= '0;
      end else begin
         clearing_ff    <= clearing_in;
         clr_addr_ff    <= clr_addr_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         solid_count_ff <= solid_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff      <= cmd_type'(req_command);
         s1_cell_x_ff   <= req_cell_x;
         s1_cell_y_ff   <= req_cell_y;
         s1_row_bits_ff <= req_row_bits;
         s1_last_row_ff <= req_last_row;
         s1_index_ff    <= req_cell_index;
      end
      if (s1_query && s2_free) begin
         s2_in_range_ff <= query_in_range;
      end
      if (s2_adv) begin
         rsp_solid_ff    <= s2_in_range_ff ? ram_rdata : 1'b1;
         rsp_in_range_ff <= s2_in_range_ff;
      end
   end

   // --------------------------------------------------------------------------
   // counting lanes and merge
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      mog_lane #(
         .LANE_IDX (l)
      ) u_lane (
         .lane_bits  (s1_row_bits_ff[l*LANE_W +: LANE_W]),
         .cell_size  (cell_eff),
         .lane_count (lane_counts[l])
      );
   end

   mog_merge u_merge (
      .lane_counts (lane_counts),
      .count_prev  (solid_count_ff),
      .cell_size   (cell_eff),
      .result      (merge_out)
   );

   // --------------------------------------------------------------------------
   // solid map
   always_comb begin
      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = 1'b1;
      end else begin
         ram_we    = s1_sample && s1_last_row_ff && write_in_range;
         ram_waddr = ADDR_W'(cell_idx);
         ram_wdata = merge_out.vote;
      end
      ram_re    = s1_query && s2_free;
      ram_raddr = ADDR_W'(s1_index_ff);
   end

   mog_ram #(
      .DATA_W (1),
      .DEPTH  (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_solid    = rsp_solid_ff;
   assign rsp_in_range = rsp_in_range_ff;

   // --------------------------------------------------------------------------
   // assertions
   a_clear_ends_at_last : assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> $past(clr_addr_ff) == LAST_ADDR)
      else $error("clearing pass ended early");

   a_outside_is_solid : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_in_range_ff) |-> rsp_solid_ff)
      else $error("out-of-range result not solid");

   a_last_row_clears : assert property (@(posedge clock) disable iff (reset)
      (s1_sample && s1_last_row_ff) |=> (solid_count_ff == '0))
      else $error("count not cleared after last row");

   a_read_from_query : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !$past(s2_valid_ff)) |-> $past(s1_query))
      else $error("map read without a query");

   a_no_write_on_query : assert property (@(posedge clock) disable iff (reset)
      (s1_query && !clearing_ff) |-> !ram_we)
      else $error("map write during a query");

endmodule
